// ===== rtl/gkc_pkg.sv =====
// ============================================================================
// gkc_pkg: shared constants and types of the Gabor coefficient generator
// Fixed-point constants, the CORDIC angle table and pipeline latencies.
// ============================================================================
package gkc_pkg;

    // Field widths
    localparam int ROW_W  = 7;
    localparam int HALF_W = 7;
    localparam int CFG_W  = 16;
    localparam int COEF_W = 16;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_HALF_SIZE = 2'd0,
        CFG_SIGMA     = 2'd1,
        CFG_ANGLE     = 2'd2,
        CFG_FREQUENCY = 2'd3
    } t_cfg_idx;

    localparam logic [HALF_W-1:0] HALF_SIZE_RST = 7'd8;
    localparam logic [CFG_W-1:0]  SIGMA_RST     = 16'd804;
    localparam logic [CFG_W-1:0]  ANGLE_RST     = 16'd0;
    localparam logic [CFG_W-1:0]  FREQUENCY_RST = 16'd4096;

    // Parameter defaults
    localparam int MAX_HALF_SIZE_DEF = 64;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    // Q30 / Q32 constants
    localparam logic signed [31:0] INV_GAIN_Q30   = 32'sd652032874;
    localparam logic signed [30:0] INV_TWO_PI_Q32 = 31'sd683565276;
    localparam logic signed [32:0] DC_TERM_Q30    = 33'sd7722226;
    localparam logic [30:0]        ONE_Q30        = 31'd1073741824;
    // exp(-1) as given by the truncated 13-term series in Q30
    localparam logic [28:0]        EXP_NEG_ONE    = 29'd395007543;

    // Arctangent of 2^-i in turns, 32-bit fraction of a full circle
    localparam logic [31:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Envelope arithmetic
    localparam int D_W           = 15;  // x*x + y*y
    localparam int U_W           = 20;  // Q16 exponent argument below 16.0
    localparam int SERIES_TERMS  = 13;
    localparam int POW_STAGES    = 15;
    localparam int DIV_LAT       = U_W + 1;
    localparam int EXP_LAT       = 1 + 3 * (SERIES_TERMS - 1) + POW_STAGES;

endpackage

// ===== rtl/gkc_in_if.sv =====
// ============================================================================
// gkc_in_if: tap position channel
// Valid/ready channel carrying one kernel row and column per word.
// ============================================================================
interface gkc_in_if;
    logic                        valid;
    logic                        ready;
    logic [gkc_pkg::ROW_W-1:0]   row;
    logic [gkc_pkg::ROW_W-1:0]   col;

    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

// ===== rtl/gkc_out_if.sv =====
// ============================================================================
// gkc_out_if: coefficient channel
// Valid/ready channel carrying one complex coefficient per word.
// ============================================================================
interface gkc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [gkc_pkg::COEF_W-1:0]  real_part;
    logic signed [gkc_pkg::COEF_W-1:0]  imag_part;
    logic                               out_of_range;

    modport source (output valid, output real_part, output imag_part,
                    output out_of_range, input ready);
    modport sink   (input valid, input real_part, input imag_part,
                    input out_of_range, output ready);
endinterface

// ===== rtl/gkc_cordic.sv =====
// ============================================================================
// gkc_cordic: pipelined circular CORDIC, turns in, Q30 cosine and sine out
// One rotation per stage after a quadrant fold, then a registered unfold.
// ============================================================================
module gkc_cordic #(
    parameter int STAGES = gkc_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    logic [1:0]         w_q0;
    logic [31:0]        w_r0;
    logic signed [31:0] r_x [0:STAGES-1];
    logic signed [31:0] r_y [0:STAGES-1];
    logic signed [31:0] r_z [0:STAGES-2];
    logic [1:0]         r_q [0:STAGES-1];
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;

    // Nearest quadrant, the residual stays within an eighth of a turn.
    assign w_q0 = 2'((i_phase + 32'h2000_0000) >> 30);
    assign w_r0 = i_phase - {w_q0, 30'd0};

    generate
        for (genvar i = 0; i < STAGES; i++) begin : g_iter
            logic signed [31:0] x_in;
            logic signed [31:0] y_in;
            logic signed [31:0] z_in;
            logic [1:0]         q_in;

            if (i == 0) begin : g_first
                assign x_in = gkc_pkg::INV_GAIN_Q30;
                assign y_in = 32'sd0;
                assign z_in = $signed(w_r0);
                assign q_in = w_q0;
            end else begin : g_next
                assign x_in = r_x[i-1];
                assign y_in = r_y[i-1];
                assign z_in = r_z[i-1];
                assign q_in = r_q[i-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!z_in[31]) begin
                        r_x[i] <= x_in - (y_in >>> i);
                        r_y[i] <= y_in + (x_in >>> i);
                    end else begin
                        r_x[i] <= x_in + (y_in >>> i);
                        r_y[i] <= y_in - (x_in >>> i);
                    end
                    r_q[i] <= q_in;
                end
            end

            if (i < STAGES - 1) begin : g_angle
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        if (!z_in[31]) begin
                            r_z[i] <= z_in - $signed(gkc_pkg::ATAN_TURNS[i]);
                        end else begin
                            r_z[i] <= z_in + $signed(gkc_pkg::ATAN_TURNS[i]);
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[STAGES-1])
                2'd0: begin
                    r_cos <= r_x[STAGES-1];
                    r_sin <= r_y[STAGES-1];
                end
                2'd1: begin
                    r_cos <= -r_y[STAGES-1];
                    r_sin <= r_x[STAGES-1];
                end
                2'd2: begin
                    r_cos <= -r_x[STAGES-1];
                    r_sin <= -r_y[STAGES-1];
                end
                default: begin
                    r_cos <= r_y[STAGES-1];
                    r_sin <= -r_x[STAGES-1];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== rtl/gkc_div.sv =====
// ============================================================================
// gkc_div: pipelined restoring divider for the envelope argument
// Gives floor(d * 2^24 / sigma) one quotient bit per stage, with a flag
// for quotients of 16.0 and above.
// ============================================================================
module gkc_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [gkc_pkg::D_W-1:0]     i_d,
    input  logic [gkc_pkg::CFG_W-1:0]   i_sig,
    output logic [gkc_pkg::U_W-1:0]     o_u,
    output logic                        o_sat
);

    localparam int UW = gkc_pkg::U_W;
    localparam int SW = gkc_pkg::CFG_W;

    logic [SW-1:0] r_rem0;
    logic          r_sat0;
    logic [SW-1:0] r_rem [0:UW-2];
    logic [UW-1:0] r_q   [0:UW-1];
    logic          r_sat [0:UW-1];

    // The upper part of the dividend is d << 4; if it already reaches sigma
    // the quotient is at least 2^20.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= SW'({i_d, 4'd0});
            r_sat0 <= ({i_d, 4'd0} >= (gkc_pkg::D_W + 4)'(i_sig));
        end
    end

    generate
        for (genvar k = 0; k < UW; k++) begin : g_bit
            logic [SW-1:0] rem_in;
            logic [UW-1:0] q_in;
            logic          sat_in;
            logic [SW:0]   trial;
            logic          ge;

            if (k == 0) begin : g_first
                assign rem_in = r_rem0;
                assign q_in   = '0;
                assign sat_in = r_sat0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign q_in   = r_q[k-1];
                assign sat_in = r_sat[k-1];
            end

            assign trial = {rem_in, 1'b0};
            assign ge    = (trial >= {1'b0, i_sig});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[k]   <= {q_in[UW-2:0], ge};
                    r_sat[k] <= sat_in;
                end
            end

            if (k < UW - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k] <= ge ? SW'(trial - {1'b0, i_sig}) : trial[SW-1:0];
                    end
                end
            end
        end
    endgenerate

    assign o_u   = r_q[UW-1];
    assign o_sat = r_sat[UW-1];

endmodule

// ===== rtl/gkc_exp.sv =====
// ============================================================================
// gkc_exp: pipelined envelope exp(-u) for a Q16 argument below 16.0
// Series of exp(-frac) term by term, then one rounded multiply by exp(-1)
// per stage for the integer part.
// ============================================================================
module gkc_exp (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [gkc_pkg::U_W-1:0]  i_u,
    input  logic                     i_sat,
    output logic [30:0]              o_e
);

    localparam int NSTEP = gkc_pkg::SERIES_TERMS - 1;
    localparam int NPOW  = gkc_pkg::POW_STAGES;

    // Count word: saturation flag on top of the integer part of u.
    logic [29:0]        r_r    [0:NSTEP-1];
    logic [30:0]        r_term [0:NSTEP-1];
    logic signed [33:0] r_sum  [0:NSTEP];
    logic [4:0]         r_cnt  [0:NSTEP];
    logic [30:0]        r_e    [0:NPOW-1];
    logic [3:0]         r_pc   [0:NPOW-2];
    logic [29:0]        w_r0;
    logic [30:0]        w_e0;

    assign w_r0 = {i_u[15:0], 14'd0};

    // The first term of the series is r itself.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]    <= w_r0;
            r_term[0] <= {1'b0, w_r0};
            r_sum[0]  <= $signed({3'd0, gkc_pkg::ONE_Q30}) - $signed({4'd0, w_r0});
            r_cnt[0]  <= {i_sat, i_u[19:16]};
        end
    end

    generate
        for (genvar j = 0; j < NSTEP; j++) begin : g_term
            localparam int K = j + 2;
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);

            logic [60:0]        w_pa;
            logic [62:0]        w_pb;
            logic [34:0]        w_qk;
            logic [30:0]        w_rem;
            logic [30:0]        w_q;
            logic [30:0]        ta;
            logic signed [33:0] suma;
            logic [4:0]         cnta;
            logic [30:0]        qb;
            logic [30:0]        tb;
            logic signed [33:0] sumb;
            logic [4:0]         cntb;

            assign w_pa = 61'(r_term[j]) * 61'(r_r[j]);
            // Reciprocal estimate is low by at most one; one compare fixes it.
            assign w_pb  = 63'(ta) * 63'(RECIP);
            assign w_qk  = 35'(qb) * 35'(K);
            assign w_rem = tb - w_qk[30:0];
            assign w_q   = qb + 31'(w_rem >= 31'(K));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    ta   <= w_pa[60:30];
                    suma <= r_sum[j];
                    cnta <= r_cnt[j];
                    qb   <= w_pb[62:32];
                    tb   <= ta;
                    sumb <= suma;
                    cntb <= cnta;
                    if ((K % 2) == 1) begin
                        r_sum[j+1] <= sumb - $signed({3'd0, w_q});
                    end else begin
                        r_sum[j+1] <= sumb + $signed({3'd0, w_q});
                    end
                    r_cnt[j+1] <= cntb;
                end
            end

            if (j < NSTEP - 1) begin : g_carry
                logic [29:0] ra;
                logic [29:0] rb;

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        ra          <= r_r[j];
                        rb          <= ra;
                        r_r[j+1]    <= rb;
                        r_term[j+1] <= w_q;
                    end
                end
            end
        end
    endgenerate

    assign w_e0 = (r_cnt[NSTEP][4] || r_sum[NSTEP] < 0) ? 31'd0 : r_sum[NSTEP][30:0];

    generate
        for (genvar j = 0; j < NPOW; j++) begin : g_pow
            logic [30:0] e_in;
            logic [3:0]  c_in;
            logic [60:0] w_pm;

            if (j == 0) begin : g_first
                assign e_in = w_e0;
                assign c_in = r_cnt[NSTEP][3:0];
            end else begin : g_next
                assign e_in = r_e[j-1];
                assign c_in = r_pc[j-1];
            end

            assign w_pm = 61'(e_in) * 61'(gkc_pkg::EXP_NEG_ONE) + (61'd1 << 29);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_e[j] <= (4'(j) < c_in) ? w_pm[60:30] : e_in;
                end
            end

            if (j < NPOW - 1) begin : g_cnt
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_pc[j] <= c_in;
                    end
                end
            end
        end
    endgenerate

    assign o_e = r_e[NPOW-1];

endmodule

// ===== rtl/gabor_kernel_coefficient_gen.sv =====
// ============================================================================
// gabor_kernel_coefficient_gen: Gabor kernel coefficient pipeline
// One complex Q1.15 coefficient per kernel tap position.
// ============================================================================
//
//  channel   dir  handshake     payload
//  i_tap     in   valid/ready   row[6:0], col[6:0]
//  o_coef    out  valid/ready   real_part[15:0], imag_part[15:0], out_of_range
//  i_cfg_*   in   write enable  i_cfg_idx selects the register, i_cfg_data[15:0]
//
// One word enters per cycle while the output is not stalled; the envelope path
// is the longest (21 divider stages, 37 series stages and 15 power stages).
// All stages advance together; a stalled output freezes the whole pipeline,
// so nothing is dropped or repeated.
// Reset is synchronous; it clears the valid bits and loads the configuration defaults.
//
module gabor_kernel_coefficient_gen #(
    parameter int MAX_HALF_SIZE = gkc_pkg::MAX_HALF_SIZE_DEF,
    parameter int CORDIC_STAGES = gkc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    gkc_in_if.sink                       i_tap,
    gkc_out_if.source                    o_coef,
    input  logic                         i_cfg_we,
    input  gkc_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [gkc_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int N = (CORDIC_STAGES < gkc_pkg::ATAN_ENTRIES) ?
                       CORDIC_STAGES : gkc_pkg::ATAN_ENTRIES;
    localparam int ENV_DONE = 1 + gkc_pkg::DIV_LAT + gkc_pkg::EXP_LAT;
    localparam int PH_DONE  = 2 * (N + 1) + 3;
    localparam int DLY      = ENV_DONE - PH_DONE;
    localparam int LAT      = ENV_DONE + 3;

    // Configuration
    logic [gkc_pkg::HALF_W-1:0] r_half_size;
    logic [gkc_pkg::CFG_W-1:0]  r_sigma;
    logic [gkc_pkg::CFG_W-1:0]  r_angle;
    logic [gkc_pkg::CFG_W-1:0]  r_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_size <= gkc_pkg::HALF_SIZE_RST;
            r_sigma     <= gkc_pkg::SIGMA_RST;
            r_angle     <= gkc_pkg::ANGLE_RST;
            r_freq      <= gkc_pkg::FREQUENCY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gkc_pkg::CFG_HALF_SIZE: r_half_size <= i_cfg_data[gkc_pkg::HALF_W-1:0];
                gkc_pkg::CFG_SIGMA:     r_sigma     <= i_cfg_data;
                gkc_pkg::CFG_ANGLE:     r_angle     <= i_cfg_data;
                gkc_pkg::CFG_FREQUENCY: r_freq      <= i_cfg_data;
            endcase
        end
    end

    // Pipeline control
    logic w_en;
    logic r_vld [0:LAT-1];
    logic r_oor [0:LAT-1];

    assign w_en        = !r_vld[LAT-1] || o_coef.ready;
    assign i_tap.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_tap.valid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Stage 0: offsets, kernel bounds and the orientation in turns
    logic [gkc_pkg::HALF_W-1:0] w_h;
    logic                       w_oor;
    logic signed [47:0]         w_pa_full;
    logic signed [7:0]          r_x0;
    logic signed [7:0]          r_y0;
    logic [31:0]                r_pa;

    assign w_h = (int'(r_half_size) > MAX_HALF_SIZE) ?
                 gkc_pkg::HALF_W'(MAX_HALF_SIZE) : r_half_size;
    assign w_oor = ({1'b0, i_tap.row} >= {w_h, 1'b0}) ||
                   ({1'b0, i_tap.col} >= {w_h, 1'b0});
    assign w_pa_full = $signed(r_angle) * gkc_pkg::INV_TWO_PI_Q32 + 48'sd4096;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0     <= $signed({1'b0, i_tap.col}) - $signed({1'b0, w_h});
            r_y0     <= $signed({1'b0, i_tap.row}) - $signed({1'b0, w_h});
            r_pa     <= w_pa_full[44:13];
            r_oor[0] <= w_oor;
            for (int i = 1; i < LAT; i++) begin
                r_oor[i] <= r_oor[i-1];
            end
        end
    end

    // Envelope path
    logic signed [15:0]          w_xx;
    logic signed [15:0]          w_yy;
    logic [gkc_pkg::D_W-1:0]     r_d;
    logic [gkc_pkg::CFG_W-1:0]   w_sig;
    logic [gkc_pkg::U_W-1:0]     w_u;
    logic                        w_sat;
    logic [30:0]                 w_e;

    assign w_xx  = r_x0 * r_x0;
    assign w_yy  = r_y0 * r_y0;
    assign w_sig = (r_sigma == '0) ? gkc_pkg::CFG_W'(1) : r_sigma;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d <= gkc_pkg::D_W'(w_xx + w_yy);
        end
    end

    gkc_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_d),
        .i_sig (w_sig),
        .o_u   (w_u),
        .o_sat (w_sat)
    );

    gkc_exp u_exp (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_u   (w_u),
        .i_sat (w_sat),
        .o_e   (w_e)
    );

    // Phase path
    logic signed [31:0] w_ca;
    logic signed [31:0] w_sa;
    logic signed [7:0]  r_xd [0:N];
    logic signed [7:0]  r_yd [0:N];
    logic signed [40:0] w_w;
    logic [43:0]        r_w;
    logic [37:0]        r_fl;
    logic [37:0]        r_fh;
    logic [43:0]        w_fs;
    logic [31:0]        r_pt;
    logic signed [31:0] w_ct;
    logic signed [31:0] w_st;
    logic signed [31:0] r_cd_c [0:DLY-1];
    logic signed [31:0] r_cd_s [0:DLY-1];

    gkc_cordic #(.STAGES(N)) u_cordic_angle (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_pa),
        .o_cos   (w_ca),
        .o_sin   (w_sa)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xd[0] <= r_x0;
            r_yd[0] <= r_y0;
            for (int i = 1; i <= N; i++) begin
                r_xd[i] <= r_xd[i-1];
                r_yd[i] <= r_yd[i-1];
            end
        end
    end

    // Only the low 44 bits of the rotated offset reach the 32-bit phase.
    assign w_w  = r_yd[N] * w_ca - r_xd[N] * w_sa;
    assign w_fs = {r_fh[21:0], 22'd0} + {6'd0, r_fl} + 44'd2048;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w  <= {{3{w_w[40]}}, w_w};
            r_fl <= 38'(r_freq) * 38'(r_w[21:0]);
            r_fh <= 38'(r_freq) * 38'(r_w[43:22]);
            r_pt <= w_fs[43:12];
        end
    end

    gkc_cordic #(.STAGES(N)) u_cordic_phase (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_pt),
        .o_cos   (w_ct),
        .o_sin   (w_st)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd_c[0] <= w_ct;
            r_cd_s[0] <= w_st;
            for (int i = 1; i < DLY; i++) begin
                r_cd_c[i] <= r_cd_c[i-1];
                r_cd_s[i] <= r_cd_s[i-1];
            end
        end
    end

    // Products and output register
    function automatic logic signed [15:0] sat16(input logic signed [64:0] p);
        logic signed [65:0] s;
        logic signed [20:0] q;
        s = {p[64], p} + 66'sd17592186044416;
        q = 21'(s >>> 45);
        if (q > 21'sd32767) begin
            return 16'sh7FFF;
        end else if (q < -21'sd32768) begin
            return 16'sh8000;
        end else begin
            return q[15:0];
        end
    endfunction

    logic signed [32:0] w_vim;
    logic signed [64:0] r_pre;
    logic signed [64:0] r_pim;
    logic signed [15:0] r_real;
    logic signed [15:0] r_imag;

    assign w_vim = {r_cd_c[DLY-1][31], r_cd_c[DLY-1]} - gkc_pkg::DC_TERM_Q30;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pre <= $signed({1'b0, w_e}) * r_cd_s[DLY-1];
            r_pim <= $signed({1'b0, w_e}) * w_vim;
            if (r_oor[LAT-2]) begin
                r_real <= '0;
                r_imag <= '0;
            end else begin
                r_real <= sat16(r_pre);
                r_imag <= sat16(r_pim);
            end
        end
    end

    assign o_coef.valid        = r_vld[LAT-1];
    assign o_coef.real_part    = r_real;
    assign o_coef.imag_part    = r_imag;
    assign o_coef.out_of_range = r_oor[LAT-1];

    // Checks
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_coef.valid && o_coef.out_of_range |->
            o_coef.real_part == '0 && o_coef.imag_part == '0)
        else $error("out-of-range word carries nonzero coefficients");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tap.valid && i_tap.ready |=> r_vld[0])
        else $error("accepted word did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_coef.valid && !o_coef.ready |=> $stable(r_vld[0]) && $stable(r_vld[LAT/2]))
        else $error("pipeline moved during an output stall");

endmodule
